@@ sv/pl0_token_scanner_core_macros.svh @@
// ----------------------------------------------------------------------------
// PL/0 token scanner assertion macros
// Shared assertion shorthands for the scanner modules. Each module that uses
// them has a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef PL0_TOKEN_SCANNER_CORE_MACROS_SVH
`define PL0_TOKEN_SCANNER_CORE_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define PL0TS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold at a clock edge.
`define PL0TS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/pl0ts_pkg.sv @@
// ----------------------------------------------------------------------------
// PL/0 token scanner package
// Types, token kind codes, keyword table and helper functions shared by the
// scanner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pl0ts_pkg;

    // Width of the byte offset and run length counters (8 to 32).
    localparam int POS_BITS        = 16;
    // Number of leading identifier bytes kept for keyword matching (9 to 16).
    localparam int KW_MAX_LEN      = 9;
    localparam int KW_IDX_BITS     = $clog2(KW_MAX_LEN);
    localparam int KW_LEN_BITS     = $clog2(KW_MAX_LEN + 1);
    localparam int KW_COUNT        = 11;
    localparam int KW_TEXT_LEN     = 9;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] FIELD_MAX = 16'hFFFF;

    // Token kind codes.
    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_INT     = 5'd1;
    localparam logic [4:0] KIND_KW_BASE = 5'd2;
    localparam logic [4:0] KIND_BANG    = 5'd13;
    localparam logic [4:0] KIND_LT      = 5'd14;
    localparam logic [4:0] KIND_LE      = 5'd15;
    localparam logic [4:0] KIND_COMMA   = 5'd16;
    localparam logic [4:0] KIND_GT      = 5'd17;
    localparam logic [4:0] KIND_GE      = 5'd18;
    localparam logic [4:0] KIND_EQ      = 5'd19;
    localparam logic [4:0] KIND_SEMI    = 5'd20;
    localparam logic [4:0] KIND_HASH    = 5'd21;
    localparam logic [4:0] KIND_QUERY   = 5'd22;
    localparam logic [4:0] KIND_ASSIGN  = 5'd23;
    localparam logic [4:0] KIND_LPAREN  = 5'd24;
    localparam logic [4:0] KIND_RPAREN  = 5'd25;
    localparam logic [4:0] KIND_SLASH   = 5'd26;
    localparam logic [4:0] KIND_STAR    = 5'd27;
    localparam logic [4:0] KIND_PLUS    = 5'd28;
    localparam logic [4:0] KIND_MINUS   = 5'd29;
    localparam logic [4:0] KIND_EOF     = 5'd30;
    localparam logic [4:0] KIND_ERROR   = 5'd31;

    // Keywords, right-justified: the last character sits in the lowest byte.
    localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "odd", "if", "then", "while", "begin", "end",
        "call", "const", "var", "procedure", "do"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3, 4'd9, 4'd2
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_LT,
        MODE_GT,
        MODE_COLON
    } mode_t;

    typedef logic [7:0] kw_buf_t [KW_MAX_LEN];

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
    } token_t;

    // Tokens caused by one input item: tok_a always, tok_b when two is set.
    typedef struct packed {
        logic   two;
        token_t tok_a;
        token_t tok_b;
    } rec_t;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == '1) ? v : v + POS_BITS'(1);
    endfunction

    function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+15:0] w;
        w = (POS_BITS + 16)'(v);
        if (w > (POS_BITS + 16)'(FIELD_MAX))
            return FIELD_MAX;
        return w[15:0];
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            "!":     k = KIND_BANG;
            ",":     k = KIND_COMMA;
            "=":     k = KIND_EQ;
            ";":     k = KIND_SEMI;
            "#":     k = KIND_HASH;
            "?":     k = KIND_QUERY;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "/":     k = KIND_SLASH;
            "*":     k = KIND_STAR;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // Keyword kind for an identifier of length len_i held in kwb, else ident.
    function automatic logic [4:0] kw_lookup(input kw_buf_t kwb,
                                             input logic [KW_LEN_BITS-1:0] len_i);
        logic [4:0] kind;
        logic       hit;
        kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (len_i == KW_LEN_BITS'(KW_LEN[i]));
            for (int j = 0; j < KW_TEXT_LEN; j++) begin
                if (j < int'(KW_LEN[i])) begin
                    if (kwb[j] != KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8])
                        hit = 1'b0;
                end
            end
            if (hit)
                kind = KIND_KW_BASE + 5'(i);
        end
        return kind;
    endfunction

endpackage

@@ sv/pl0ts_front.sv @@
// ----------------------------------------------------------------------------
// PL/0 token scanner front end
// Accepts source bytes, runs the scanning state machine and hands the tokens
// caused by each byte to the token queue as one record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pl0_token_scanner_core_macros.svh"

module pl0ts_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              push,
    output pl0ts_pkg::rec_t   rec
);

    pl0ts_pkg::mode_t                 mode_reg, mode_next;
    logic [pl0ts_pkg::POS_BITS-1:0]   pos_reg, pos_next;
    logic [pl0ts_pkg::POS_BITS-1:0]   begin_reg, begin_next;
    logic [pl0ts_pkg::POS_BITS-1:0]   run_reg, run_next;
    logic                             halted_reg, halted_next;
    pl0ts_pkg::kw_buf_t               kwbuf_reg;

    logic                             accept;
    logic                             kw_we;
    logic [pl0ts_pkg::KW_IDX_BITS-1:0] kw_idx;
    logic                             pend_valid, scan_valid, do_scan;
    pl0ts_pkg::token_t                pend_tok, scan_tok;
    logic [4:0]                       ident_kind, op_kind;
    logic                             is_letter, is_digit, is_space;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign is_letter = char_code inside {["a":"z"], ["A":"Z"]};
    assign is_digit  = char_code inside {["0":"9"]};
    assign is_space  = char_code inside {8'd32, 8'd10, 8'd9};
    assign op_kind   = pl0ts_pkg::single_kind(char_code);

    always_comb
    begin
        if (run_reg > pl0ts_pkg::POS_BITS'(pl0ts_pkg::KW_MAX_LEN))
            ident_kind = pl0ts_pkg::KIND_IDENT;
        else
            ident_kind = pl0ts_pkg::kw_lookup(kwbuf_reg,
                                              run_reg[pl0ts_pkg::KW_LEN_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pl0ts_pkg::MODE_IDLE;
            pos_reg    <= '0;
            begin_reg  <= '0;
            run_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            run_reg    <= run_next;
            halted_reg <= halted_next;
        end
    end

    // The keyword buffer is only read at entries the current identifier wrote.
    always_ff @(posedge clk)
    begin
        if (kw_we)
            kwbuf_reg[kw_idx] <= char_code;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        run_next    = run_reg;
        halted_next = halted_reg;
        kw_we       = 1'b0;
        kw_idx      = run_reg[pl0ts_pkg::KW_IDX_BITS-1:0];
        pend_valid  = 1'b0;
        scan_valid  = 1'b0;
        pend_tok    = '0;
        scan_tok    = '0;
        do_scan     = 1'b0;

        if (accept)
        begin
            if (halted_reg)
            begin
                if (end_of_text)
                begin
                    mode_next   = pl0ts_pkg::MODE_IDLE;
                    pos_next    = '0;
                    begin_next  = '0;
                    run_next    = '0;
                    halted_next = 1'b0;
                end
            end
            else if (end_of_text)
            begin
                // Flush the pending token, then end of file unless a colon hangs.
                pend_tok.token_start = pl0ts_pkg::clamp16(begin_reg);
                pend_tok.token_length = 16'd1;
                case (mode_reg)
                    pl0ts_pkg::MODE_IDENT:
                    begin
                        pend_valid = 1'b1;
                        pend_tok.token_kind = ident_kind;
                        pend_tok.token_length = pl0ts_pkg::clamp16(run_reg);
                    end
                    pl0ts_pkg::MODE_INT:
                    begin
                        pend_valid = 1'b1;
                        pend_tok.token_kind = pl0ts_pkg::KIND_INT;
                        pend_tok.token_length = pl0ts_pkg::clamp16(run_reg);
                    end
                    pl0ts_pkg::MODE_LT:
                    begin
                        pend_valid = 1'b1;
                        pend_tok.token_kind = pl0ts_pkg::KIND_LT;
                    end
                    pl0ts_pkg::MODE_GT:
                    begin
                        pend_valid = 1'b1;
                        pend_tok.token_kind = pl0ts_pkg::KIND_GT;
                    end
                    pl0ts_pkg::MODE_COLON:
                    begin
                        pend_valid = 1'b1;
                        pend_tok.token_kind = pl0ts_pkg::KIND_ERROR;
                    end
                    default:
                    begin
                        pend_valid = 1'b0;
                    end
                endcase
                if (mode_reg != pl0ts_pkg::MODE_COLON)
                begin
                    scan_valid = 1'b1;
                    scan_tok.token_kind = pl0ts_pkg::KIND_EOF;
                    scan_tok.token_start = pl0ts_pkg::clamp16(pos_reg);
                    scan_tok.token_length = 16'd0;
                end
                mode_next   = pl0ts_pkg::MODE_IDLE;
                pos_next    = '0;
                begin_next  = '0;
                run_next    = '0;
                halted_next = 1'b0;
            end
            else
            begin
                do_scan  = 1'b1;
                pos_next = pl0ts_pkg::sat_inc(pos_reg);
                pend_tok.token_start = pl0ts_pkg::clamp16(begin_reg);
                case (mode_reg)
                    pl0ts_pkg::MODE_IDENT:
                    begin
                        if (is_letter || is_digit || char_code == "_")
                        begin
                            kw_we = run_reg < pl0ts_pkg::POS_BITS'(pl0ts_pkg::KW_MAX_LEN);
                            run_next = pl0ts_pkg::sat_inc(run_reg);
                            do_scan  = 1'b0;
                        end
                        else
                        begin
                            pend_valid = 1'b1;
                            pend_tok.token_kind = ident_kind;
                            pend_tok.token_length = pl0ts_pkg::clamp16(run_reg);
                            mode_next = pl0ts_pkg::MODE_IDLE;
                        end
                    end
                    pl0ts_pkg::MODE_INT:
                    begin
                        if (is_digit)
                        begin
                            run_next = pl0ts_pkg::sat_inc(run_reg);
                            do_scan  = 1'b0;
                        end
                        else
                        begin
                            pend_valid = 1'b1;
                            pend_tok.token_kind = pl0ts_pkg::KIND_INT;
                            pend_tok.token_length = pl0ts_pkg::clamp16(run_reg);
                            mode_next = pl0ts_pkg::MODE_IDLE;
                        end
                    end
                    pl0ts_pkg::MODE_LT, pl0ts_pkg::MODE_GT, pl0ts_pkg::MODE_COLON:
                    begin
                        pend_valid = 1'b1;
                        mode_next  = pl0ts_pkg::MODE_IDLE;
                        pend_tok.token_length = 16'd1;
                        if (char_code == "=")
                        begin
                            pend_tok.token_length = 16'd2;
                            do_scan = 1'b0;
                            if (mode_reg == pl0ts_pkg::MODE_LT)
                                pend_tok.token_kind = pl0ts_pkg::KIND_LE;
                            else if (mode_reg == pl0ts_pkg::MODE_GT)
                                pend_tok.token_kind = pl0ts_pkg::KIND_GE;
                            else
                                pend_tok.token_kind = pl0ts_pkg::KIND_ASSIGN;
                        end
                        else if (mode_reg == pl0ts_pkg::MODE_COLON)
                        begin
                            // Lone colon: error, the current byte is dropped.
                            pend_tok.token_kind = pl0ts_pkg::KIND_ERROR;
                            halted_next = 1'b1;
                            do_scan = 1'b0;
                        end
                        else if (mode_reg == pl0ts_pkg::MODE_LT)
                            pend_tok.token_kind = pl0ts_pkg::KIND_LT;
                        else
                            pend_tok.token_kind = pl0ts_pkg::KIND_GT;
                    end
                    default:
                    begin
                        mode_next = pl0ts_pkg::MODE_IDLE;
                    end
                endcase

                if (do_scan)
                begin
                    scan_tok.token_start = pl0ts_pkg::clamp16(pos_reg);
                    scan_tok.token_length = 16'd1;
                    if (is_space)
                    begin
                        mode_next = pl0ts_pkg::MODE_IDLE;
                    end
                    else if (is_letter)
                    begin
                        mode_next  = pl0ts_pkg::MODE_IDENT;
                        begin_next = pos_reg;
                        run_next   = pl0ts_pkg::POS_BITS'(1);
                        kw_we      = 1'b1;
                        kw_idx     = '0;
                    end
                    else if (is_digit)
                    begin
                        mode_next  = pl0ts_pkg::MODE_INT;
                        begin_next = pos_reg;
                        run_next   = pl0ts_pkg::POS_BITS'(1);
                    end
                    else if (char_code == "<" || char_code == ">" || char_code == ":")
                    begin
                        begin_next = pos_reg;
                        run_next   = pl0ts_pkg::POS_BITS'(1);
                        if (char_code == "<")
                            mode_next = pl0ts_pkg::MODE_LT;
                        else if (char_code == ">")
                            mode_next = pl0ts_pkg::MODE_GT;
                        else
                            mode_next = pl0ts_pkg::MODE_COLON;
                    end
                    else if (op_kind != pl0ts_pkg::KIND_IDENT)
                    begin
                        scan_valid = 1'b1;
                        scan_tok.token_kind = op_kind;
                    end
                    else
                    begin
                        scan_valid = 1'b1;
                        scan_tok.token_kind = pl0ts_pkg::KIND_ERROR;
                        halted_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        rec.two   = pend_valid && scan_valid;
        rec.tok_a = pend_valid ? pend_tok : scan_tok;
        rec.tok_b = scan_tok;
        push      = pend_valid || scan_valid;
    end

    `PL0TS_ASSERT_IMPLY(a_halt_idle, halted_reg, mode_reg == pl0ts_pkg::MODE_IDLE,
        "halted scanner left a token pending")
    `PL0TS_ASSERT_IMPLY(a_push_room, push, !q_full, "record pushed into a full queue")

endmodule

@@ sv/pl0ts_queue.sv @@
// ----------------------------------------------------------------------------
// PL/0 token scanner record queue
// Short first-in first-out queue of token records between the front end and
// the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pl0_token_scanner_core_macros.svh"

module pl0ts_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pl0ts_pkg::rec_t   push_rec,
    output logic              full,
    output logic              head_valid,
    output pl0ts_pkg::rec_t   head_rec,
    input  logic              pop
);

    pl0ts_pkg::rec_t                       slot_reg [pl0ts_pkg::QUEUE_DEPTH];
    logic [pl0ts_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pl0ts_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pl0ts_pkg::QUEUE_CNT_BITS-1:0]  count_reg, count_next;

    assign full       = count_reg == pl0ts_pkg::QUEUE_CNT_BITS'(pl0ts_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_rec   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + pl0ts_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + pl0ts_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + pl0ts_pkg::QUEUE_CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - pl0ts_pkg::QUEUE_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    `PL0TS_ASSERT_IMPLY(a_pop_nonempty, pop, head_valid, "pop from an empty queue")

endmodule

@@ sv/pl0ts_back.sv @@
// ----------------------------------------------------------------------------
// PL/0 token scanner output stage
// Takes records from the queue and presents their tokens one per item on the
// output channel through a registered stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pl0_token_scanner_core_macros.svh"

module pl0ts_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  pl0ts_pkg::rec_t   head_rec,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output pl0ts_pkg::token_t out_tok,
    output logic              out_last
);

    logic              out_valid_reg, out_valid_next;
    logic              second_reg, second_next;
    pl0ts_pkg::token_t out_tok_reg, out_tok_next;
    pl0ts_pkg::token_t hold_tok_reg, hold_tok_next;
    logic              out_last_reg, out_last_next;
    logic              load;

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        out_tok_next   = out_tok_reg;
        hold_tok_next  = hold_tok_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                // Second token of a record goes out before the next record.
                out_valid_next = 1'b1;
                out_tok_next   = hold_tok_reg;
                out_last_next  = 1'b1;
                second_next    = 1'b0;
            end
            else if (head_valid)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_tok_next   = head_rec.tok_a;
                out_last_next  = !head_rec.two;
                second_next    = head_rec.two;
                hold_tok_next  = head_rec.tok_b;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        hold_tok_reg <= hold_tok_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;
    assign out_last  = out_last_reg;

    `PL0TS_ASSERT_IMPLY(a_second_shown, second_reg, out_valid_reg && !out_last_reg,
        "second token waiting behind a missing first token")

endmodule

@@ sv/pl0_token_scanner_core.sv @@
// ----------------------------------------------------------------------------
// PL/0 token scanner core
// Streaming lexer for PL/0 source text. Bytes come in on the slave channel,
// one per item; tuser[0] set marks end of text (tdata is then ignored).
// Tokens leave on the master channel, one per item: tuser holds the kind,
// tdata the start offset and length, tlast marks the final token caused by
// one input item. An input item causes zero, one or two tokens.
// The front end takes one byte every cycle while the queue has room; its scan
// state is the only thing that carries from one byte to the next. A four-record
// queue sits between the front end and the registered output stage, so a
// token passes through a queue slot and the output register after the byte
// that caused it is accepted. Output runs at one token per cycle while
// tready is high, so the two tokens of a byte leave one after the other.
// When the receiver holds tready low the output stage holds its token, the
// queue fills, and tready on the input drops only once the queue is full.
// Reset clears the scan state, the queue and the output stage; the scanner
// then starts a new text at offset zero, as it also does after end of text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pl0_token_scanner_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic              q_full;
    logic              push;
    pl0ts_pkg::rec_t   push_rec;
    logic              head_valid;
    pl0ts_pkg::rec_t   head_rec;
    logic              pop;
    pl0ts_pkg::token_t out_tok;

    pl0ts_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .char_code   (s_axis_tdata),
        .end_of_text (s_axis_tuser[0]),
        .q_full      (q_full),
        .push        (push),
        .rec         (push_rec)
    );

    // Records hold all tokens of a byte: one per cycle unless the queue is full.
    pl0ts_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop)
    );

    pl0ts_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_tok    (out_tok),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_tok.token_length, out_tok.token_start};
    assign m_axis_tuser = out_tok.token_kind;

endmodule

@@ tb/pl0_token_scanner_core_tb.sv @@
// ----------------------------------------------------------------------------
// PL/0 token scanner core testbench
// Streams PL/0 source bytes into the scanner and checks every token against a
// scan state tracker kept in this bench. Directed texts cover keywords,
// operators, pending tokens flushed at end of text, error and halt handling.
// Random texts follow, with random gaps on the input side and random stalls
// on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pl0_token_scanner_core_tb;

    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    // One token as it should leave the scanner.
    typedef struct {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } scanned_token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] char_code
    logic [0:0]  s_axis_tuser = 1'b0;      // [0] end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;             // [15:0] token_start, [31:16] token_length
    logic [4:0]  m_axis_tuser;             // [4:0] token_kind
    logic        m_axis_tlast;             // last_of_run

    pl0_token_scanner_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Keywords in the order of their kind codes, starting at KIND_KW_BASE.
    string keyword_words [11] = '{
        "odd", "if", "then", "while", "begin", "end",
        "call", "const", "var", "procedure", "do"
    };
    string operator_texts [17] = '{
        "!", "<", "<=", ",", ">", ">=", "=", ";", "#", "?", ":=",
        "(", ")", "/", "*", "+", "-"
    };
    string blanks = " \n\t";

    // Scan state tracked alongside the scanner.
    pl0ts_pkg::mode_t                scan_state;
    logic [pl0ts_pkg::POS_BITS-1:0]  next_offset;
    logic [pl0ts_pkg::POS_BITS-1:0]  tok_begin;
    logic [pl0ts_pkg::POS_BITS-1:0]  tok_run;
    logic [7:0]                      word_buf [pl0ts_pkg::KW_MAX_LEN];
    logic                            halted;

    scanned_token_t step_tokens[$];
    scanned_token_t expected_tokens[$];

    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;
    int error_count    = 0;
    int tokens_checked = 0;
    int items_sent     = 0;
    int live_items     = 0;
    int texts_ended    = 0;
    int quiet_cycles   = 0;

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic void clear_scan();
        scan_state  = pl0ts_pkg::MODE_IDLE;
        next_offset = '0;
        tok_begin   = '0;
        tok_run     = '0;
        halted      = 1'b0;
    endfunction

    function automatic logic [pl0ts_pkg::POS_BITS-1:0] bump_offset(
        input logic [pl0ts_pkg::POS_BITS-1:0] v);
        return (v == {pl0ts_pkg::POS_BITS{1'b1}}) ? v : v + pl0ts_pkg::POS_BITS'(1);
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Kind of a one-byte operator; KIND_ERROR for anything not recognized.
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        case (c)
            "!":     return pl0ts_pkg::KIND_BANG;
            ",":     return pl0ts_pkg::KIND_COMMA;
            "=":     return pl0ts_pkg::KIND_EQ;
            ";":     return pl0ts_pkg::KIND_SEMI;
            "#":     return pl0ts_pkg::KIND_HASH;
            "?":     return pl0ts_pkg::KIND_QUERY;
            "(":     return pl0ts_pkg::KIND_LPAREN;
            ")":     return pl0ts_pkg::KIND_RPAREN;
            "/":     return pl0ts_pkg::KIND_SLASH;
            "*":     return pl0ts_pkg::KIND_STAR;
            "+":     return pl0ts_pkg::KIND_PLUS;
            "-":     return pl0ts_pkg::KIND_MINUS;
            default: return pl0ts_pkg::KIND_ERROR;
        endcase
    endfunction

    // Identifiers longer than the keyword buffer can never be keywords.
    function automatic logic [4:0] word_kind();
        logic [4:0] kind;
        bit         same;
        kind = pl0ts_pkg::KIND_IDENT;
        if (tok_run <= pl0ts_pkg::KW_MAX_LEN)
        begin
            for (int k = 0; k < 11; k++)
            begin
                if (keyword_words[k].len() == tok_run)
                begin
                    same = 1'b1;
                    for (int j = 0; j < keyword_words[k].len(); j++)
                    begin
                        if (word_buf[j] != keyword_words[k][j])
                            same = 1'b0;
                    end
                    if (same)
                        kind = pl0ts_pkg::KIND_KW_BASE + 5'(k);
                end
            end
        end
        return kind;
    endfunction

    function automatic void add_token(input logic [4:0] kind,
                                      input logic [pl0ts_pkg::POS_BITS-1:0] start,
                                      input logic [pl0ts_pkg::POS_BITS-1:0] len);
        scanned_token_t t;
        t.kind   = kind;
        t.start  = (start > 65535) ? 16'hFFFF : 16'(start);
        t.length = (len > 65535) ? 16'hFFFF : 16'(len);
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    // Advances the scan state by one input item and leaves the tokens it
    // causes in step_tokens, the final one flagged as last.
    function automatic void scan_byte(input logic [7:0] c, input logic eot);
        bit             rescan;
        scanned_token_t t;
        step_tokens.delete();
        rescan = 1'b0;
        if (halted)
        begin
            if (eot)
                clear_scan();
        end
        else if (eot)
        begin
            case (scan_state)
                pl0ts_pkg::MODE_IDENT:
                    add_token(word_kind(), tok_begin, tok_run);
                pl0ts_pkg::MODE_INT:
                    add_token(pl0ts_pkg::KIND_INT, tok_begin, tok_run);
                pl0ts_pkg::MODE_LT:
                    add_token(pl0ts_pkg::KIND_LT, tok_begin, pl0ts_pkg::POS_BITS'(1));
                pl0ts_pkg::MODE_GT:
                    add_token(pl0ts_pkg::KIND_GT, tok_begin, pl0ts_pkg::POS_BITS'(1));
                pl0ts_pkg::MODE_COLON:
                    add_token(pl0ts_pkg::KIND_ERROR, tok_begin, pl0ts_pkg::POS_BITS'(1));
                default:    ;
            endcase
            // A dangling colon ends the text with its error and no eof.
            if (scan_state != pl0ts_pkg::MODE_COLON)
                add_token(pl0ts_pkg::KIND_EOF, next_offset, '0);
            clear_scan();
        end
        else
        begin
            case (scan_state)
                pl0ts_pkg::MODE_IDENT:
                    if (is_letter(c) || is_digit(c) || c == "_")
                    begin
                        if (tok_run < pl0ts_pkg::KW_MAX_LEN)
                            word_buf[tok_run[pl0ts_pkg::KW_IDX_BITS-1:0]] = c;
                        tok_run     = bump_offset(tok_run);
                        next_offset = bump_offset(next_offset);
                    end
                    else
                    begin
                        add_token(word_kind(), tok_begin, tok_run);
                        rescan = 1'b1;
                    end
                pl0ts_pkg::MODE_INT:
                    if (is_digit(c))
                    begin
                        tok_run     = bump_offset(tok_run);
                        next_offset = bump_offset(next_offset);
                    end
                    else
                    begin
                        add_token(pl0ts_pkg::KIND_INT, tok_begin, tok_run);
                        rescan = 1'b1;
                    end
                pl0ts_pkg::MODE_LT, pl0ts_pkg::MODE_GT, pl0ts_pkg::MODE_COLON:
                    if (c == "=")
                    begin
                        add_token((scan_state == pl0ts_pkg::MODE_LT) ? pl0ts_pkg::KIND_LE :
                                  (scan_state == pl0ts_pkg::MODE_GT) ? pl0ts_pkg::KIND_GE :
                                  pl0ts_pkg::KIND_ASSIGN,
                                  tok_begin, pl0ts_pkg::POS_BITS'(2));
                        scan_state  = pl0ts_pkg::MODE_IDLE;
                        next_offset = bump_offset(next_offset);
                    end
                    else if (scan_state == pl0ts_pkg::MODE_COLON)
                    begin
                        // The byte after a lone colon is swallowed.
                        add_token(pl0ts_pkg::KIND_ERROR, tok_begin, pl0ts_pkg::POS_BITS'(1));
                        scan_state  = pl0ts_pkg::MODE_IDLE;
                        halted      = 1'b1;
                        next_offset = bump_offset(next_offset);
                    end
                    else
                    begin
                        add_token((scan_state == pl0ts_pkg::MODE_LT) ? pl0ts_pkg::KIND_LT :
                                  pl0ts_pkg::KIND_GT,
                                  tok_begin, pl0ts_pkg::POS_BITS'(1));
                        rescan = 1'b1;
                    end
                default:
                    rescan = 1'b1;
            endcase
            if (rescan)
            begin
                scan_state = pl0ts_pkg::MODE_IDLE;
                if (c == " " || c == 8'h0A || c == 8'h09)
                begin
                end
                else if (is_letter(c))
                begin
                    scan_state  = pl0ts_pkg::MODE_IDENT;
                    tok_begin   = next_offset;
                    tok_run     = pl0ts_pkg::POS_BITS'(1);
                    word_buf[0] = c;
                end
                else if (is_digit(c))
                begin
                    scan_state = pl0ts_pkg::MODE_INT;
                    tok_begin  = next_offset;
                    tok_run    = pl0ts_pkg::POS_BITS'(1);
                end
                else if (c == "<" || c == ">" || c == ":")
                begin
                    scan_state = (c == "<") ? pl0ts_pkg::MODE_LT :
                                 (c == ">") ? pl0ts_pkg::MODE_GT : pl0ts_pkg::MODE_COLON;
                    tok_begin  = next_offset;
                    tok_run    = pl0ts_pkg::POS_BITS'(1);
                end
                else
                begin
                    add_token(punct_kind(c), next_offset, pl0ts_pkg::POS_BITS'(1));
                    if (punct_kind(c) == pl0ts_pkg::KIND_ERROR)
                        halted = 1'b1;
                end
                next_offset = bump_offset(next_offset);
            end
        end
        if (step_tokens.size() > 0)
        begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        gap = src_gaps ? pause_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // Bytes swallowed while halted do not count as useful stimulus.
        if (!halted)
            live_items++;
        items_sent++;
        if (eot)
            texts_ended++;
        scan_byte(c, eot);
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Holds the input idle until every predicted token has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1) == 1)
            return 8'(65 + $urandom_range(0, 25));
        return 8'(97 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return random_letter();
        if (r < 9)
            return 8'(48 + $urandom_range(0, 9));
        return "_";
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, result checking and the watchdog
    // ------------------------------------------------------------------
    initial
    begin : sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (!sink_stalls)
            begin
                m_axis_tready <= 1'b1;
                hold = 0;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else if (m_axis_tready && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold = pause_len();
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin : check_tokens
        scanned_token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tokens_checked++;
            if (expected_tokens.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected token: expected none, got kind %0d start %0d length %0d",
                         $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    error_count++;
                    $display("%0t: token kind: expected %0d, got %0d",
                             $time, want.kind, m_axis_tuser);
                end
                if (m_axis_tdata[15:0] !== want.start)
                begin
                    error_count++;
                    $display("%0t: token start: expected %0d, got %0d",
                             $time, want.start, m_axis_tdata[15:0]);
                end
                if (m_axis_tdata[31:16] !== want.length)
                begin
                    error_count++;
                    $display("%0t: token length: expected %0d, got %0d",
                             $time, want.length, m_axis_tdata[31:16]);
                end
                if (m_axis_tlast !== want.last)
                begin
                    error_count++;
                    $display("%0t: last of run: expected %0b, got %0b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d tokens still expected",
                     $time, WATCHDOG_LIMIT, expected_tokens.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // All eleven keywords, a near miss by case and one too long to match.
    task automatic test_keywords();
        send_text("odd if then while begin end call const var procedure do Do procedurex");
        send_item(8'h00, 1'b1);
    endtask

    // Every operator, identifiers and integers ended by the next byte, and
    // a pending '>' flushed at end of text.
    task automatic test_operators();
        send_text("x+12)!,;#?(/*-=<=a>=b<c:=9\t\n>");
        send_item(8'hFF, 1'b1);
    endtask

    // Pending tokens at end of text, empty texts, lone colons and unknown
    // bytes, including extreme byte values and the halt that follows.
    task automatic test_flush_and_errors();
        send_text("ab");
        send_item(8'h00, 1'b1);
        send_text("907");
        send_item(8'h00, 1'b1);
        send_text("<");
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b1);
        send_text(":");
        send_item(8'h00, 1'b1);
        send_text(":a b");
        send_item(8'h00, 1'b1);
        send_text("_ok");
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        send_text("q\r");
        send_item(8'h00, 1'b1);
    endtask

    // One random text: mostly well-formed tokens with random spelling and
    // spacing, now and then a stray byte or a lone colon.
    task automatic send_random_text();
        int ntok;
        int pick;
        int k;
        int len;
        ntok = $urandom_range(1, 12);
        for (int n = 0; n < ntok; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
            begin
                k = $urandom_range(0, 10);
                case ($urandom_range(0, 3))
                    0:       len = keyword_words[k].len() - 1;
                    default: len = keyword_words[k].len();
                endcase
                if (len == 0)
                    len = 1;
                for (int j = 0; j < len; j++)
                    send_item(keyword_words[k][j], 1'b0);
                if ($urandom_range(0, 5) == 0)
                    send_item(random_word_char(), 1'b0);
            end
            else if (pick < 42)
            begin
                send_item(random_letter(), 1'b0);
                len = $urandom_range(0, 11);
                repeat (len) send_item(random_word_char(), 1'b0);
            end
            else if (pick < 56)
            begin
                len = $urandom_range(1, 6);
                repeat (len) send_item(8'(48 + $urandom_range(0, 9)), 1'b0);
            end
            else if (pick < 88)
            begin
                send_text(operator_texts[$urandom_range(0, 16)]);
            end
            else if (pick < 89)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick < 90)
            begin
                send_item(":", 1'b0);
            end
            else
            begin
                send_item(blanks[$urandom_range(0, 2)], 1'b0);
            end
            if ($urandom_range(0, 9) < 6)
                send_item(blanks[$urandom_range(0, 2)], 1'b0);
        end
        // Most texts end properly; the rest run on into the next one.
        if ($urandom_range(0, 9) != 0)
            send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_random_texts();
        int live_start;
        live_start = live_items;
        while (live_items - live_start < RANDOM_ITEMS)
        begin
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            send_random_text();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        clear_scan();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        test_keywords();
        test_operators();
        wait_drained();
        test_flush_and_errors();
        wait_drained();
        test_random_texts();

        sink_stalls = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d input items over %0d texts, %0d tokens checked, %0d mismatches",
                 items_sent, texts_ended, tokens_checked, error_count);
        $display("tb: keywords, operators, end-of-text flushes, errors, halts and random texts");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
